[rtl/qbdc_pkg.sv]
// ----------------------------------------------------------------------------
// qbdc_pkg
// Shared constants and types for the quad button debounce counter.
// ----------------------------------------------------------------------------
package qbdc_pkg;

  localparam int NUM_BUTTONS    = 4;   // debounced buttons held in state
  localparam int PIN_BITS       = 4;   // pins present on the sample beat
  localparam int OUT_BUTTONS    = 4;   // buttons reported on the result beat
  localparam int TIME_WIDTH     = 32;  // timestamp arithmetic width
  localparam int STAMP_WIDTH    = 32;  // now_ms field width
  localparam int CNT_WIDTH      = 32;
  localparam int TOTAL_WIDTH    = 34;
  localparam int MODE_WIDTH     = 2;
  localparam int CFG_WIDTH      = 16;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int RISE_CNT_WIDTH = $clog2(OUT_BUTTONS + 1);

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [CNT_WIDTH-1:0]   cnt_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_t;
  typedef logic [MODE_WIDTH-1:0]  mode_t;
  typedef logic [TOTAL_WIDTH-1:0] total_t;

  // register select, taken from paddr[2]
  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_LOCKOUT  = 1'b1;

  localparam cfg_t DEBOUNCE_RST = CFG_WIDTH'(200);
  localparam cfg_t LOCKOUT_RST  = CFG_WIDTH'(300);

  // per-button status towards the top level
  typedef struct packed {
    logic stable;  // debounced state (registered)
    logic rise;    // becomes pressed in the current step
    logic wrap;    // counter wraps in the current step
  } btn_stat_t;

endpackage

[rtl/qbdc_in_if.sv]
// ----------------------------------------------------------------------------
// qbdc_in_if
// Sample channel: raw pin levels and millisecond timestamp.
// ----------------------------------------------------------------------------
interface qbdc_in_if;

  logic                                valid;
  logic                                ready;
  logic [qbdc_pkg::PIN_BITS-1:0]       pin_levels;
  logic [qbdc_pkg::STAMP_WIDTH-1:0]    now_ms;

  modport source (output valid, output pin_levels, output now_ms, input ready);
  modport sink   (input valid, input pin_levels, input now_ms, output ready);

endinterface

[rtl/qbdc_out_if.sv]
// ----------------------------------------------------------------------------
// qbdc_out_if
// Result channel: debounced states, press flags, mode and counters.
// ----------------------------------------------------------------------------
interface qbdc_out_if;

  logic                                 valid;
  logic                                 ready;
  logic [qbdc_pkg::OUT_BUTTONS-1:0]     pressed_mask;
  logic [qbdc_pkg::OUT_BUTTONS-1:0]     new_press_mask;
  logic [qbdc_pkg::MODE_WIDTH-1:0]      display_mode;
  logic                                 mode_changed;
  logic [qbdc_pkg::CNT_WIDTH-1:0]       count_first;
  logic [qbdc_pkg::CNT_WIDTH-1:0]       count_second;
  logic [qbdc_pkg::CNT_WIDTH-1:0]       count_third;
  logic [qbdc_pkg::CNT_WIDTH-1:0]       count_fourth;
  logic [qbdc_pkg::TOTAL_WIDTH-1:0]     total_presses;

  modport source (
    output valid, output pressed_mask, output new_press_mask, output display_mode,
    output mode_changed, output count_first, output count_second, output count_third,
    output count_fourth, output total_presses, input ready
  );
  modport sink (
    input valid, input pressed_mask, input new_press_mask, input display_mode,
    input mode_changed, input count_first, input count_second, input count_third,
    input count_fourth, input total_presses, output ready
  );

endinterface

[rtl/quad_button_debounce_counter.sv]
// ----------------------------------------------------------------------------
// quad_button_debounce_counter
// Pipeline: an accepted sample is held in the stage 1 register, then stepped
// into the state and result registers, from which it leaves as a result beat.
// Throughput: one sample per cycle; a stalled result holds the pipe for that cycle.
// Rate is set by the state update (debounce, counters, mode) in stage 2.
// Reset (rst_n, synchronous): states, counters, mode and timers clear to zero,
// debounce_ms to 200 and mode_lockout_ms to 300; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quad_button_debounce_counter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  qbdc_in_if.sink                                in_beat,
  qbdc_out_if.source                             out_beat,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [qbdc_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [qbdc_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [qbdc_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                   pready
);

  // --------------------------------------------------------------------------
  // Configuration registers (APB, zero wait state)
  // --------------------------------------------------------------------------
  qbdc_pkg::cfg_t debounce_r;
  qbdc_pkg::cfg_t lockout_r;
  logic           cfg_wr;
  logic           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];  // registers sit at byte offsets 0 and 4

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= qbdc_pkg::DEBOUNCE_RST;
      lockout_r  <= qbdc_pkg::LOCKOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        qbdc_pkg::REG_DEBOUNCE: debounce_r <= pwdata[qbdc_pkg::CFG_WIDTH-1:0];
        qbdc_pkg::REG_LOCKOUT:  lockout_r  <= pwdata[qbdc_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      qbdc_pkg::REG_DEBOUNCE: prdata = qbdc_pkg::APB_DATA_WIDTH'(debounce_r);
      qbdc_pkg::REG_LOCKOUT:  prdata = qbdc_pkg::APB_DATA_WIDTH'(lockout_r);
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: sample register
  // --------------------------------------------------------------------------
  logic                              s1_valid_r;
  logic [qbdc_pkg::PIN_BITS-1:0]     s1_pins_r;
  qbdc_pkg::time_t                   s1_now_r;
  logic                              out_valid_r;
  logic                              step_en;

  // stage 2 fires when a sample is waiting and the result slot is free or leaving
  assign step_en       = s1_valid_r && (!out_valid_r || out_beat.ready);
  assign in_beat.ready = !s1_valid_r || step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat.ready) begin
      s1_valid_r <= in_beat.valid;
    end
  end

  // payload: no reset; the timestamp is taken modulo 2^TIME_WIDTH
  always_ff @(posedge clk) begin
    if (in_beat.valid && in_beat.ready) begin
      s1_pins_r <= in_beat.pin_levels;
      s1_now_r  <= qbdc_pkg::TIME_WIDTH'(in_beat.now_ms);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: per-button debounce and counters
  // --------------------------------------------------------------------------
  qbdc_pkg::btn_stat_t stat [qbdc_pkg::NUM_BUTTONS];
  qbdc_pkg::cnt_t      cnt  [qbdc_pkg::NUM_BUTTONS];

  for (genvar b = 0; b < qbdc_pkg::NUM_BUTTONS; b++) begin : g_btn
    logic reading;
    if (b < qbdc_pkg::PIN_BITS) begin : g_pin
      assign reading = !s1_pins_r[b];  // active-low pin
    end else begin : g_nopin
      assign reading = 1'b0;           // no pin: never pressed
    end

    qbdc_button u_button (
      .clk         (clk),
      .rst_n       (rst_n),
      .step_en     (step_en),
      .reading     (reading),
      .now         (s1_now_r),
      .debounce_ms (debounce_r),
      .stat        (stat[b]),
      .count       (cnt[b])
    );
  end

  // reported view: buttons that do not exist read as zero
  logic [qbdc_pkg::OUT_BUTTONS-1:0] rise_vec;
  logic [qbdc_pkg::OUT_BUTTONS-1:0] wrap_vec;
  logic [qbdc_pkg::OUT_BUTTONS-1:0] stable_vec;
  qbdc_pkg::cnt_t                   out_cnt [qbdc_pkg::OUT_BUTTONS];

  for (genvar b = 0; b < qbdc_pkg::OUT_BUTTONS; b++) begin : g_out
    if (b < qbdc_pkg::NUM_BUTTONS) begin : g_have
      assign rise_vec[b]   = stat[b].rise;
      assign wrap_vec[b]   = stat[b].wrap;
      assign stable_vec[b] = stat[b].stable;
      assign out_cnt[b]    = cnt[b];
    end else begin : g_none
      assign rise_vec[b]   = 1'b0;
      assign wrap_vec[b]   = 1'b0;
      assign stable_vec[b] = 1'b0;
      assign out_cnt[b]    = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Display mode: button one's new press advances it, outside the lockout
  // --------------------------------------------------------------------------
  qbdc_pkg::mode_t mode_r;
  qbdc_pkg::time_t mode_time_r;
  qbdc_pkg::time_t mode_elapsed;
  logic            mode_adv;

  assign mode_elapsed = s1_now_r - mode_time_r;
  assign mode_adv     = stat[0].rise &&
                        (mode_elapsed > qbdc_pkg::TIME_WIDTH'(lockout_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= '0;
      mode_time_r <= '0;
    end else if (step_en && mode_adv) begin
      mode_r      <= mode_r + qbdc_pkg::MODE_WIDTH'(1);  // wraps 3 -> 0
      mode_time_r <= s1_now_r;
    end
  end

  // --------------------------------------------------------------------------
  // Running total: tracks the sum of the reported counters. Each new press
  // adds one, each counter wrap takes 2^32 back off.
  // --------------------------------------------------------------------------
  qbdc_pkg::total_t                        total_r;
  qbdc_pkg::total_t                        total_nxt;
  logic [qbdc_pkg::RISE_CNT_WIDTH-1:0]     rise_cnt;
  logic [qbdc_pkg::RISE_CNT_WIDTH-1:0]     wrap_cnt;

  always_comb begin
    rise_cnt = '0;
    wrap_cnt = '0;
    for (int b = 0; b < qbdc_pkg::OUT_BUTTONS; b++) begin
      rise_cnt = rise_cnt + qbdc_pkg::RISE_CNT_WIDTH'(rise_vec[b]);
      wrap_cnt = wrap_cnt + qbdc_pkg::RISE_CNT_WIDTH'(wrap_vec[b]);
    end
    total_nxt = total_r + qbdc_pkg::TOTAL_WIDTH'(rise_cnt)
              - (qbdc_pkg::TOTAL_WIDTH'(wrap_cnt) << qbdc_pkg::CNT_WIDTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (step_en) begin
      total_r <= total_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register. Stable states, counters, mode and total are the state
  // registers themselves: they move only when the next step fires, which is
  // also when the result beat is replaced.
  // --------------------------------------------------------------------------
  logic [qbdc_pkg::OUT_BUTTONS-1:0] new_press_r;
  logic                             mode_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      new_press_r    <= rise_vec;
      mode_changed_r <= mode_adv;
    end
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.pressed_mask   = stable_vec;
  assign out_beat.new_press_mask = new_press_r;
  assign out_beat.display_mode   = mode_r;
  assign out_beat.mode_changed   = mode_changed_r;
  assign out_beat.count_first    = out_cnt[0];
  assign out_beat.count_second   = out_cnt[1];
  assign out_beat.count_third    = out_cnt[2];
  assign out_beat.count_fourth   = out_cnt[3];
  assign out_beat.total_presses  = total_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  // a mode advance only comes from a new press of button one
  a_mode_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && mode_changed_r |-> new_press_r[0])
    else $error("mode advanced without a new press of button one");

  // a new press is always reflected in the debounced state
  a_press_is_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((new_press_r & ~stable_vec) == '0))
    else $error("new press flagged on a button not pressed");

  // the running total equals the sum of the reported counters
  a_total_sum: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == (qbdc_pkg::TOTAL_WIDTH'(out_cnt[0]) + qbdc_pkg::TOTAL_WIDTH'(out_cnt[1])
              + qbdc_pkg::TOTAL_WIDTH'(out_cnt[2]) + qbdc_pkg::TOTAL_WIDTH'(out_cnt[3])))
    else $error("running total out of step with the counters");

  // state holds while the result beat is stalled
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_beat.ready |=> $stable(total_r) && $stable(mode_r)
                                        && $stable(new_press_r))
    else $error("state moved while result beat stalled");

  // a step that advances the mode moves it on by exactly one
  a_mode_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && mode_adv |=> mode_r == $past(mode_r) + qbdc_pkg::MODE_WIDTH'(1))
    else $error("display mode did not advance by one");
`endif

endmodule

[rtl/qbdc_button.sv]
// ----------------------------------------------------------------------------
// qbdc_button
// One button: timer debounce on the raw reading and a wrapping press counter.
// ----------------------------------------------------------------------------
module qbdc_button (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic                reading,      // 1 = pressed
  input  qbdc_pkg::time_t     now,
  input  qbdc_pkg::cfg_t      debounce_ms,
  output qbdc_pkg::btn_stat_t stat,
  output qbdc_pkg::cnt_t      count
);

  logic            prev_r;
  logic            stable_r;
  qbdc_pkg::time_t change_time_r;
  qbdc_pkg::cnt_t  count_r;

  logic            changed;
  logic            accept;
  qbdc_pkg::time_t elapsed;

  // a fresh change restarts the timer at now and is never accepted in that step
  assign changed = (reading != prev_r);
  assign elapsed = now - change_time_r;
  assign accept  = !changed && (elapsed > qbdc_pkg::TIME_WIDTH'(debounce_ms)) &&
                   (reading != stable_r);

  assign stat.stable = stable_r;
  assign stat.rise   = accept && reading;
  assign stat.wrap   = accept && reading && (count_r == '1);
  assign count       = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r        <= 1'b0;
      stable_r      <= 1'b0;
      change_time_r <= '0;
      count_r       <= '0;
    end else if (step_en) begin
      prev_r <= reading;
      if (changed) begin
        change_time_r <= now;
      end
      if (accept) begin
        stable_r <= reading;
      end
      if (accept && reading) begin
        count_r <= count_r + qbdc_pkg::CNT_WIDTH'(1);
      end
    end
  end

endmodule

[sim/quad_button_debounce_counter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_button_debounce_counter_tb
// Drives pin samples with timestamps through the sample channel under random
// stalls on both sides. A tracker class keeps its own copy of the debounce
// state and counters and checks each result beat field by field. The APB
// registers are rewritten between phases, extremes included, and read back.
// ----------------------------------------------------------------------------
module quad_button_debounce_counter_tb;

  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles tolerated before giving up
  localparam int PHASE_SAMPLES  = 240;   // random samples per register setting
  localparam int DRAIN_CYCLES   = 4;     // margin for the pipe to drain

  // one result beat, as predicted or as seen on the result channel
  typedef struct packed {
    logic [qbdc_pkg::OUT_BUTTONS-1:0] pressed;
    logic [qbdc_pkg::OUT_BUTTONS-1:0] fresh;
    qbdc_pkg::mode_t                  mode;
    logic                             changed;
    qbdc_pkg::cnt_t [3:0]             count;
    qbdc_pkg::total_t                 total;
  } press_report_t;

  // --------------------------------------------------------------------------
  // Tracker: own debounce state, predicts a report per accepted sample
  // --------------------------------------------------------------------------
  class press_tracker;
    logic [3:0]       last_raw;    // previous pressed reading per button
    logic [3:0]       settled;     // debounced pressed state
    qbdc_pkg::time_t  stamp[4];    // time of last raw change
    qbdc_pkg::cnt_t   presses[4];
    qbdc_pkg::mode_t  mode;
    qbdc_pkg::time_t  mode_stamp;
    qbdc_pkg::cfg_t   debounce;
    qbdc_pkg::cfg_t   lockout;
    press_report_t    pending_reports[$];
    int               errors;

    function new();
      last_raw   = '0;
      settled    = '0;
      mode       = '0;
      mode_stamp = '0;
      debounce   = qbdc_pkg::DEBOUNCE_RST;
      lockout    = qbdc_pkg::LOCKOUT_RST;
      errors     = 0;
      for (int b = 0; b < 4; b++) begin
        stamp[b]   = '0;
        presses[b] = '0;
      end
    endfunction

    function void set_reg(logic idx, qbdc_pkg::cfg_t value);
      if (idx == qbdc_pkg::REG_DEBOUNCE) debounce = value;
      else lockout = value;
    endfunction

    function void note_sample(logic [3:0] pins, qbdc_pkg::time_t now);
      press_report_t   r;
      logic            reading;
      qbdc_pkg::time_t held_for;
      r = '0;
      for (int b = 0; b < 4; b++) begin
        reading = ~pins[b];
        if (reading != last_raw[b]) stamp[b] = now;
        held_for = now - stamp[b];
        if (held_for > {16'd0, debounce} && reading != settled[b]) begin
          settled[b] = reading;
          if (reading) begin
            presses[b] = presses[b] + 1'b1;
            r.fresh[b] = 1'b1;
            held_for = now - mode_stamp;
            if (b == 0 && held_for > {16'd0, lockout}) begin
              mode       = mode + 1'b1;
              mode_stamp = now;
              r.changed  = 1'b1;
            end
          end
        end
        last_raw[b] = reading;
      end
      r.pressed = settled;
      r.mode    = mode;
      for (int b = 0; b < 4; b++) begin
        r.count[b] = presses[b];
        r.total    = r.total + qbdc_pkg::total_t'(presses[b]);
      end
      pending_reports.push_back(r);
    endfunction

    function void cmp(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_report(press_report_t got);
      press_report_t want;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result beat with none expected, actual %0h", $time, got);
        return;
      end
      want = pending_reports.pop_front();
      cmp("pressed_mask",   64'(want.pressed),  64'(got.pressed));
      cmp("new_press_mask", 64'(want.fresh),    64'(got.fresh));
      cmp("display_mode",   64'(want.mode),     64'(got.mode));
      cmp("mode_changed",   64'(want.changed),  64'(got.changed));
      cmp("count_first",    64'(want.count[0]), 64'(got.count[0]));
      cmp("count_second",   64'(want.count[1]), 64'(got.count[1]));
      cmp("count_third",    64'(want.count[2]), 64'(got.count[2]));
      cmp("count_fourth",   64'(want.count[3]), 64'(got.count[3]));
      cmp("total_presses",  64'(want.total),    64'(got.total));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, APB port, DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  qbdc_in_if  in_ch ();
  qbdc_out_if out_ch ();

  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [qbdc_pkg::APB_ADDR_WIDTH-1:0] paddr;
  logic [qbdc_pkg::APB_DATA_WIDTH-1:0] pwdata;
  logic [qbdc_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic                                pready;

  quad_button_debounce_counter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_ch),
    .out_beat (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  press_tracker tracker;

  bit              steady;        // no idling on either side while set
  int              samples_sent;
  int              idle_cycles;
  int              stall_left;
  qbdc_pkg::time_t cursor;        // running millisecond clock of the stimulus
  logic [3:0]      held;          // pin levels the buttons are meant to settle at
  int              cur_debounce;
  int              cur_lockout;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, checking on every accepted beat
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    stall_left   = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    press_report_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.pressed  = out_ch.pressed_mask;
      got.fresh    = out_ch.new_press_mask;
      got.mode     = out_ch.display_mode;
      got.changed  = out_ch.mode_changed;
      got.count[0] = out_ch.count_first;
      got.count[1] = out_ch.count_second;
      got.count[2] = out_ch.count_third;
      got.count[3] = out_ch.count_fourth;
      got.total    = out_ch.total_presses;
      tracker.check_report(got);
    end
  end

  // watchdog: any beat or APB transfer counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("quad_button_debounce_counter_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; all are entered and left just after a falling edge
  // --------------------------------------------------------------------------
  task automatic send_sample(logic [3:0] pins, qbdc_pkg::time_t now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pin_levels <= pins;
    in_ch.now_ms     <= now;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_sample(pins, now);
    samples_sent++;
    @(negedge clk);
  endtask

  // let every expected beat drain before touching the registers
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(logic idx, qbdc_pkg::cfg_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= qbdc_pkg::APB_DATA_WIDTH'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(logic idx, qbdc_pkg::cfg_t want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[qbdc_pkg::CFG_WIDTH-1:0] !== want) begin
      tracker.errors++;
      $display("%0t: register %0d read back, expected %0h, actual %0h",
               $time, idx, want, prdata[qbdc_pkg::CFG_WIDTH-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(int deb, int lock);
    wait_idle();
    reg_write(qbdc_pkg::REG_DEBOUNCE, qbdc_pkg::cfg_t'(deb));
    reg_write(qbdc_pkg::REG_LOCKOUT, qbdc_pkg::cfg_t'(lock));
    reg_read_check(qbdc_pkg::REG_DEBOUNCE, qbdc_pkg::cfg_t'(deb));
    reg_read_check(qbdc_pkg::REG_LOCKOUT, qbdc_pkg::cfg_t'(lock));
    cur_debounce = deb;
    cur_lockout  = lock;
  endtask

  // short step of the running clock, at most a quarter of the debounce time plus one
  function automatic qbdc_pkg::time_t jitter();
    return qbdc_pkg::time_t'($urandom_range(0, cur_debounce / 4 + 1));
  endfunction

  // --------------------------------------------------------------------------
  // Random phase: mostly clean press/release sequences with bounce,
  // some aborted glitches, some pure noise
  // --------------------------------------------------------------------------
  task automatic play_phase(int quota);
    int         start;
    int         r;
    int         bounces;
    logic [3:0] target;
    start  = samples_sent;
    cursor = 32'hFFFF_FFFF - qbdc_pkg::time_t'($urandom_range(0, 4 * cur_debounce + 2000));
    while (samples_sent - start < quota) begin
      if ((samples_sent % 50) == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        target  = held ^ 4'($urandom_range(1, 15));
        bounces = $urandom_range(0, 3);
        repeat (bounces) begin
          cursor += jitter();
          send_sample(target ^ 4'($urandom), cursor);
        end
        cursor += jitter();
        send_sample(target, cursor);
        if ($urandom_range(0, 3) == 0) begin
          // sits exactly on the debounce time, then one past it
          cursor += qbdc_pkg::time_t'(cur_debounce);
          send_sample(target, cursor);
          cursor += 1;
        end else begin
          cursor += qbdc_pkg::time_t'(cur_debounce + 1
                                      + $urandom_range(0, cur_lockout / 2 + 2));
        end
        send_sample(target, cursor);
        held = target;
      end else if (r < 90) begin
        // glitch that returns before the window closes
        cursor += jitter();
        send_sample(held ^ 4'($urandom_range(1, 15)), cursor);
        cursor += qbdc_pkg::time_t'($urandom_range(0, cur_debounce));
        send_sample(held, cursor);
      end else begin
        cursor = $urandom;
        send_sample(4'($urandom), cursor);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int deb_set[5];
    int lock_set[5];
    deb_set  = '{0, 65535, 3, -1, 200};
    lock_set = '{0, 65535, 17, -1, 300};

    tracker          = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.pin_levels = '1;
    in_ch.now_ms     = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    idle_cycles      = 0;
    samples_sent     = 0;
    steady           = 1'b0;
    held             = 4'hF;
    cur_debounce     = 200;
    cur_lockout      = 300;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, reset register values (200 / 300)
    send_sample(4'hF, 32'd0);
    send_sample(4'h0, 32'd0);        // fresh change, never taken at once
    send_sample(4'h0, 32'd200);      // exactly on debounce time: not yet
    send_sample(4'h0, 32'd201);      // all pressed; lockout after reset holds mode
    send_sample(4'hF, 32'd202);
    send_sample(4'hF, 32'd403);      // all released
    send_sample(4'hE, 32'd500);
    send_sample(4'hE, 32'd701);      // button one press advances mode
    send_sample(4'hF, 32'd702);
    send_sample(4'hF, 32'd903);
    send_sample(4'hE, 32'd904);
    send_sample(4'hE, 32'd1105);
    send_sample(4'h7, 32'd1106);     // button one released, button four pressed
    send_sample(4'h7, 32'd1307);
    send_sample(4'hF, 32'hFFFF_FF00);
    send_sample(4'hA, 32'hFFFF_FFF0);
    send_sample(4'hA, 32'h0000_00C0); // press held across the timestamp wrap
    send_sample(4'h5, 32'h0000_00C1);
    send_sample(4'h5, 32'hFFFF_FFFF);
    send_sample(4'h0, 32'hFFFF_FFFF);
    send_sample(4'h0, 32'h0000_0000);
    send_sample(4'h0, 32'h7FFF_FFFF);
    send_sample(4'hF, 32'h8000_0000);
    send_sample(4'hF, 32'hFFFF_FFFE);
    held = 4'hF;

    for (int p = 0; p < 5; p++) begin
      apply_settings(deb_set[p]  < 0 ? $urandom_range(0, 1000) : deb_set[p],
                     lock_set[p] < 0 ? $urandom_range(0, 2000) : lock_set[p]);
      play_phase(PHASE_SAMPLES);
    end

    // drain and settle
    in_ch.valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
      $display("quad_button_debounce_counter_tb: clean");
    end else begin
      $display("quad_button_debounce_counter_tb: errors");
    end
    $finish;
  end

endmodule
